// ----- hw/rtl/ecr_pkg.sv -----
package ecr_pkg;

  localparam int ELEV_W  = 17;
  localparam int RGB_W   = 24;
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int NUM_W   = 15;
  localparam int DEN_W   = 15;
  localparam int RECIP_W = 12;
  localparam int PROD_W  = CH_W + NUM_W;
  localparam int MUL_W   = PROD_W + RECIP_W;
  localparam int RECIP_SHIFT = PROD_W;
  localparam int REM_W   = DEN_W + 1;
  localparam int CFG_IDX_W = 3;

  localparam logic [ELEV_W-1:0] ELEV_ONE = 17'd65536;
  localparam logic [ELEV_W-1:0] BP_COAST    = 17'd26214;
  localparam logic [ELEV_W-1:0] BP_BEACH    = 17'd32768;
  localparam logic [ELEV_W-1:0] BP_PLAIN    = 17'd36045;
  localparam logic [ELEV_W-1:0] BP_FOREST   = 17'd49152;
  localparam logic [ELEV_W-1:0] BP_HILL     = 17'd55706;

  typedef enum logic [2:0] {
    BAND_OCEAN  = 3'd0,
    BAND_COAST  = 3'd1,
    BAND_BEACH  = 3'd2,
    BAND_PLAIN  = 3'd3,
    BAND_FOREST = 3'd4,
    BAND_HILL   = 3'd5
  } band_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OCEAN    = 3'd0,
    CFG_COAST    = 3'd1,
    CFG_BEACH    = 3'd2,
    CFG_PLAIN    = 3'd3,
    CFG_FOREST   = 3'd4,
    CFG_HILL     = 3'd5,
    CFG_MOUNTAIN = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    band_e             band;
    logic [NUM_W-1:0]  num;
    logic [RGB_W-1:0]  lo_rgb;
    logic [RGB_W-1:0]  hi_rgb;
  } entry_t;

  function automatic logic [ELEV_W-1:0] bp_lo_of(band_e band);
    logic [ELEV_W-1:0] bp;
    case (band)
      BAND_OCEAN:  bp = '0;
      BAND_COAST:  bp = BP_COAST;
      BAND_BEACH:  bp = BP_BEACH;
      BAND_PLAIN:  bp = BP_PLAIN;
      BAND_FOREST: bp = BP_FOREST;
      BAND_HILL:   bp = BP_HILL;
      default:     bp = '0;
    endcase
    return bp;
  endfunction

  function automatic logic [DEN_W-1:0] den_of(band_e band);
    logic [DEN_W-1:0] den;
    case (band)
      BAND_OCEAN:  den = 15'd26214;
      BAND_COAST:  den = 15'd6554;
      BAND_BEACH:  den = 15'd3277;
      BAND_PLAIN:  den = 15'd13107;
      BAND_FOREST: den = 15'd6554;
      BAND_HILL:   den = 15'd9830;
      default:     den = 15'd26214;
    endcase
    return den;
  endfunction

  // floor(2^RECIP_SHIFT / den)
  function automatic logic [RECIP_W-1:0] recip_of(band_e band);
    logic [RECIP_W-1:0] r;
    case (band)
      BAND_OCEAN:  r = 12'd320;
      BAND_COAST:  r = 12'd1279;
      BAND_BEACH:  r = 12'd2559;
      BAND_PLAIN:  r = 12'd640;
      BAND_FOREST: r = 12'd1279;
      BAND_HILL:   r = 12'd853;
      default:     r = 12'd320;
    endcase
    return r;
  endfunction

endpackage

// ----- hw/rtl/ecr_front.sv -----
module ecr_front import ecr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RGB_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ELEV_W-1:0]    elevation_i,
  input  logic                 q_full_i,
  output logic                 q_push_o,
  output entry_t               q_entry_o
);

  logic [RGB_W-1:0] ocean_q, coast_q, beach_q, plain_q, forest_q, hill_q, mountain_q;
  logic [ELEV_W-1:0] elev_sat;
  logic [ELEV_W-1:0] num_full;
  band_e             band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocean_q    <= '0;
      coast_q    <= '0;
      beach_q    <= '0;
      plain_q    <= '0;
      forest_q   <= '0;
      hill_q     <= '0;
      mountain_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OCEAN:    ocean_q    <= cfg_data_i;
        CFG_COAST:    coast_q    <= cfg_data_i;
        CFG_BEACH:    beach_q    <= cfg_data_i;
        CFG_PLAIN:    plain_q    <= cfg_data_i;
        CFG_FOREST:   forest_q   <= cfg_data_i;
        CFG_HILL:     hill_q     <= cfg_data_i;
        CFG_MOUNTAIN: mountain_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    elev_sat = (elevation_i > ELEV_ONE) ? ELEV_ONE : elevation_i;
    if (elev_sat < BP_COAST) begin
      band = BAND_OCEAN;
    end else if (elev_sat < BP_BEACH) begin
      band = BAND_COAST;
    end else if (elev_sat < BP_PLAIN) begin
      band = BAND_BEACH;
    end else if (elev_sat < BP_FOREST) begin
      band = BAND_PLAIN;
    end else if (elev_sat < BP_HILL) begin
      band = BAND_FOREST;
    end else begin
      band = BAND_HILL;
    end
    num_full = elev_sat - bp_lo_of(band);
  end

  always_comb begin
    q_entry_o.band = band;
    q_entry_o.num  = num_full[NUM_W-1:0];
    unique case (band)
      BAND_OCEAN: begin
        q_entry_o.lo_rgb = ocean_q;
        q_entry_o.hi_rgb = coast_q;
      end
      BAND_COAST: begin
        q_entry_o.lo_rgb = coast_q;
        q_entry_o.hi_rgb = beach_q;
      end
      BAND_BEACH: begin
        q_entry_o.lo_rgb = beach_q;
        q_entry_o.hi_rgb = plain_q;
      end
      BAND_PLAIN: begin
        q_entry_o.lo_rgb = plain_q;
        q_entry_o.hi_rgb = forest_q;
      end
      BAND_FOREST: begin
        q_entry_o.lo_rgb = forest_q;
        q_entry_o.hi_rgb = hill_q;
      end
      default: begin
        q_entry_o.lo_rgb = hill_q;
        q_entry_o.hi_rgb = mountain_q;
      end
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

endmodule

// ----- hw/rtl/ecr_fifo.sv -----
module ecr_fifo import ecr_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

endmodule

// ----- hw/rtl/ecr_back.sv -----
module ecr_back import ecr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  entry_t          q_entry_i,
  output logic            q_pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [CH_W-1:0] red_o,
  output logic [CH_W-1:0] green_o,
  output logic [CH_W-1:0] blue_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic s1_en, s2_en, s3_en, out_en;

  band_e             s1_band_q, s2_band_q, s3_band_q;
  logic              s1_neg_q  [NUM_CH];
  logic              s2_neg_q  [NUM_CH];
  logic              s3_neg_q  [NUM_CH];
  logic [CH_W-1:0]   s1_lo_q   [NUM_CH];
  logic [CH_W-1:0]   s2_lo_q   [NUM_CH];
  logic [CH_W-1:0]   s3_lo_q   [NUM_CH];
  logic [PROD_W-1:0] s1_prod_q [NUM_CH];
  logic [PROD_W-1:0] s2_prod_q [NUM_CH];
  logic [CH_W-1:0]   s2_quot_q [NUM_CH];
  logic [CH_W-1:0]   s3_quot_q [NUM_CH];
  logic [REM_W-1:0]  s3_rem_q  [NUM_CH];
  logic [CH_W-1:0]   out_ch_q  [NUM_CH];

  logic              s1_neg_d  [NUM_CH];
  logic [CH_W-1:0]   s1_lo_d   [NUM_CH];
  logic [PROD_W-1:0] s1_prod_d [NUM_CH];
  logic [CH_W-1:0]   s2_quot_d [NUM_CH];
  logic [REM_W-1:0]  s3_rem_d  [NUM_CH];
  logic [CH_W-1:0]   out_ch_d  [NUM_CH];

  assign out_en  = !out_valid_q || !out_stall_i;
  assign s3_en   = !s3_valid_q || out_en;
  assign s2_en   = !s2_valid_q || s3_en;
  assign s1_en   = !s1_valid_q || s2_en;
  assign q_pop_o = q_valid_i && s1_en;

  // |hi - lo| * num
  always_comb begin
    logic [CH_W-1:0] lo, hi, mag;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lo  = q_entry_i.lo_rgb[RGB_W-1-CH_W*ch -: CH_W];
      hi  = q_entry_i.hi_rgb[RGB_W-1-CH_W*ch -: CH_W];
      mag = (hi < lo) ? lo - hi : hi - lo;
      s1_neg_d[ch]  = (hi < lo);
      s1_lo_d[ch]   = lo;
      s1_prod_d[ch] = PROD_W'(mag) * PROD_W'(q_entry_i.num);
    end
  end

  // quotient estimate by reciprocal, at most one short
  always_comb begin
    logic [MUL_W-1:0] full;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      full = MUL_W'(s1_prod_q[ch]) * MUL_W'(recip_of(s1_band_q));
      s2_quot_d[ch] = full[RECIP_SHIFT +: CH_W];
    end
  end

  always_comb begin
    logic [PROD_W-1:0] qd, diff;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      qd   = PROD_W'(s2_quot_q[ch]) * PROD_W'(den_of(s2_band_q));
      diff = s2_prod_q[ch] - qd;
      s3_rem_d[ch] = diff[REM_W-1:0];
    end
  end

  // correct the estimate, round the negative side toward minus infinity
  always_comb begin
    logic [REM_W-1:0] den, rem;
    logic [CH_W-1:0]  quot, mag;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      den  = REM_W'(den_of(s3_band_q));
      quot = s3_quot_q[ch];
      rem  = s3_rem_q[ch];
      if (rem >= den) begin
        quot = quot + 1'b1;
        rem  = rem - den;
      end
      mag = quot;
      if (s3_neg_q[ch] && (rem != '0)) begin
        mag = quot + 1'b1;
      end
      out_ch_d[ch] = s3_neg_q[ch] ? s3_lo_q[ch] - mag : s3_lo_q[ch] + mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= q_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_en) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_en) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_band_q <= q_entry_i.band;
      s1_neg_q  <= s1_neg_d;
      s1_lo_q   <= s1_lo_d;
      s1_prod_q <= s1_prod_d;
    end
    if (s2_en) begin
      s2_band_q <= s1_band_q;
      s2_neg_q  <= s1_neg_q;
      s2_lo_q   <= s1_lo_q;
      s2_prod_q <= s1_prod_q;
      s2_quot_q <= s2_quot_d;
    end
    if (s3_en) begin
      s3_band_q <= s2_band_q;
      s3_neg_q  <= s2_neg_q;
      s3_lo_q   <= s2_lo_q;
      s3_quot_q <= s2_quot_q;
      s3_rem_q  <= s3_rem_d;
    end
    if (out_en) begin
      out_ch_q <= out_ch_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = out_ch_q[0];
  assign green_o     = out_ch_q[1];
  assign blue_o      = out_ch_q[2];

endmodule

// ----- hw/rtl/elevation_color_ramp_top.sv -----
// Piecewise linear color ramp: each elevation beat (17-bit unsigned, 65536 = 1.0, larger
// values saturate to 1.0) yields one red/green/blue beat, exactly interpolated and rounded
// down between the two configured end colors of its band. Breakpoints are fixed at 0.4, 0.5,
// 0.55, 0.75 and 0.85; the seven colors are written at indexes 0 (ocean) to 6 (mountain)
// and reset to black; the user must write them only while no beat is in flight; the block
// does not enforce it. One beat per clock unless stalled; a result passes the queue write
// and four back stages (magnitude product, reciprocal and remainder multiplies, correction).
module elevation_color_ramp_top import ecr_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [RGB_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [ELEV_W-1:0]    elevation_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [CH_W-1:0]      red_o,
  output logic [CH_W-1:0]      green_o,
  output logic [CH_W-1:0]      blue_o
);

  logic   q_push, q_full, q_pop, q_valid;
  entry_t push_entry, pop_entry;

  ecr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elevation_i (elevation_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (push_entry)
  );

  ecr_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (pop_entry)
  );

  ecr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (pop_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("queue pushed while full");

  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |=> q_valid)
    else $error("queue empty after push");
`endif

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  import ecr_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int PALETTE_RANDOM = 0;
  localparam int PALETTE_STRIPES = 1;
  localparam int PALETTE_WHITE = 2;
  localparam int PALETTE_BYTE_EXTREMES = 3;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_OCEAN;
  logic [RGB_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [ELEV_W-1:0]    elevation_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CH_W-1:0]      red_o;
  logic [CH_W-1:0]      green_o;
  logic [CH_W-1:0]      blue_o;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;
  logic [RGB_W-1:0] palette [7];

  function automatic int unsigned knee_of(int k);
    case (k)
      0: return 0;
      1: return BP_COAST;
      2: return BP_BEACH;
      3: return BP_PLAIN;
      4: return BP_FOREST;
      5: return BP_HILL;
      default: return ELEV_ONE;
    endcase
  endfunction

  class color_ramp_checker;
    logic [RGB_W-1:0] shade [7];
    rgb_t pending_rgb [$];
    int failures;

    function new();
      foreach (shade[i]) shade[i] = '0;
      failures = 0;
    endfunction

    function void set_color(logic [CFG_IDX_W-1:0] idx, logic [RGB_W-1:0] value);
      if (idx <= CFG_MOUNTAIN) shade[idx] = value;
    endfunction

    function rgb_t ramp_color(logic [ELEV_W-1:0] raw);
      int unsigned e;
      int k;
      band_e band;
      longint num, den, lo, hi, p, q;
      logic [CH_W-1:0] ch [3];
      rgb_t c;
      e = (raw > ELEV_ONE) ? ELEV_ONE : raw;
      k = 5;
      for (int i = 0; i < 5; i++) begin
        if (e < knee_of(i + 1)) begin
          k = i;
          break;
        end
      end
      band = band_e'(k);
      num = longint'(e) - longint'(knee_of(int'(band)));
      den = longint'(knee_of(int'(band) + 1)) - longint'(knee_of(int'(band)));
      for (int j = 0; j < 3; j++) begin
        lo = shade[k][23 - 8 * j -: 8];
        hi = shade[k + 1][23 - 8 * j -: 8];
        p = (hi - lo) * num;
        if (p >= 0) begin
          q = p / den;
        end else begin
          q = -((-p + den - 1) / den);
        end
        ch[j] = 8'(lo + q);
      end
      c.red = ch[0];
      c.green = ch[1];
      c.blue = ch[2];
      return c;
    endfunction

    function void note_elevation(logic [ELEV_W-1:0] raw);
      pending_rgb.push_back(ramp_color(raw));
    endfunction

    function void check_rgb(logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        $error("unexpected color beat: red %0d green %0d blue %0d", r, g, b);
        failures++;
        return;
      end
      want = pending_rgb.pop_front();
      if (r !== want.red) begin
        $error("red: expected %0d, actual %0d", want.red, r);
        failures++;
      end
      if (g !== want.green) begin
        $error("green: expected %0d, actual %0d", want.green, g);
        failures++;
      end
      if (b !== want.blue) begin
        $error("blue: expected %0d, actual %0d", want.blue, b);
        failures++;
      end
    endfunction

    function int pending();
      return pending_rgb.size();
    endfunction
  endclass

  color_ramp_checker ramp = new();

  elevation_color_ramp_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .elevation_i (elevation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) ramp.check_rgb(red_o, green_o, blue_o);
  end

  task automatic send_elevation(logic [ELEV_W-1:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      elevation_i <= ELEV_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    elevation_i <= e;
    do @(posedge clk_i); while (in_stall_o);
    ramp.note_elevation(e);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (ramp.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_palette();
    for (int i = 0; i < 7; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i <= palette[i];
      ramp.set_color(cfg_reg_e'(i), palette[i]);
      @(posedge clk_i);
    end
    // the spare index must not touch any color
    cfg_index_i <= CFG_SPARE;
    cfg_data_i <= RGB_W'($urandom);
    ramp.set_color(CFG_SPARE, '1);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic fill_palette(int mode);
    for (int i = 0; i < 7; i++) begin
      case (mode)
        PALETTE_STRIPES: palette[i] = (i % 2 == 1) ? 24'hFFFFFF : 24'h000000;
        PALETTE_WHITE: palette[i] = 24'hFFFFFF;
        PALETTE_BYTE_EXTREMES: begin
          palette[i] = {{8{$urandom_range(1) == 1}}, {8{$urandom_range(1) == 1}},
                        {8{$urandom_range(1) == 1}}};
        end
        default: palette[i] = RGB_W'($urandom);
      endcase
    end
  endtask

  function automatic logic [ELEV_W-1:0] pick_elevation();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return ELEV_W'($urandom_range(65536));
    if (pick < 75) return ELEV_W'(knee_of($urandom_range(6)) + $urandom_range(4) - 2);
    if (pick < 85) return ELEV_W'($urandom_range(131071, 65537));
    return ELEV_W'($urandom);
  endfunction

  initial begin
    logic [ELEV_W-1:0] edges [$];
    edges = '{17'd0, 17'd1, 17'd26213, 17'd26214, 17'd26215, 17'd32767, 17'd32768,
              17'd36044, 17'd36045, 17'd49151, 17'd49152, 17'd55705, 17'd55706,
              17'd65535, 17'd65536, 17'd65537, 17'h1FFFF};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // colors still black from reset
    send_elevation(17'd0);
    send_elevation(17'd40000);
    send_elevation(17'd65536);
    drain();

    fill_palette(PALETTE_STRIPES);
    write_palette();
    foreach (edges[i]) send_elevation(edges[i]);
    drain();
    fill_palette(PALETTE_RANDOM);
    write_palette();
    send_elevation(17'd13107);
    send_elevation(17'd60000);
    send_elevation(17'd100000);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 32;
          stall_pct = 79;
        end
        1: begin
          send_idle_pct = 79;
          stall_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      for (int round = 0; round < 2; round++) begin
        fill_palette(round == 0 ? $urandom_range(3) : PALETTE_RANDOM);
        write_palette();
        if ((phase == 2 && round == 0) || (phase == 0 && round == 1)) hold_request = 150;
        for (int n = 0; n < 200; n++) begin
          send_elevation(pick_elevation());
          if (n == 100) drain();
        end
        drain();
      end
    end

    drain();
    if (ramp.failures == 0 && ramp.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
